/* hw/rtl/dtfx_pkg.sv */
// shared types and constants for the decimal text to fixed-point converter
package dtfx_pkg;

    localparam int INT_BITS_DEF        = 16;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 6;

    localparam int FD_CNT_W = 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_SEEK = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic valid;
        logic advance;
    } t_ctl;

endpackage

/* hw/rtl/dtfx_core.sv */
// parse state, digit accumulation and result register
module dtfx_core #(
    parameter int INT_BITS        = dtfx_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS       = dtfx_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dtfx_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dtfx_pkg::t_ctl                      i_ctl,
    input  logic [7:0]                          i_ch,
    output logic                                o_valid,
    output logic signed [INT_BITS+FRAC_BITS:0]  o_value,
    output logic [1:0]                          o_status,
    output logic                                o_line_end
);
    import dtfx_pkg::*;

    localparam int VW   = INT_BITS + FRAC_BITS + 1;
    localparam int FW   = FRAC_BITS + 2;
    localparam int IE   = INT_BITS + 4;
    localparam int MW   = INT_BITS + FRAC_BITS + 2;
    localparam int PW   = FW + 4;
    localparam int TIW  = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;
    localparam int TD   = 2 ** TIW;
    localparam logic [VW-1:0] MAX_MAG = {1'b0, {(VW-1){1'b1}}};

    logic [FW-1:0] w_tab [TD];

    for (genvar gk = 0; gk < TD; gk++) begin : g_weight
        if (gk < MAX_FRAC_DIGITS) begin : g_used
            localparam longint unsigned P10 = 64'd10 ** (gk + 1);
            localparam longint unsigned WT  =
                (((64'd1 << (FRAC_BITS + 1)) / P10) + 64'd1) >> 1;
            assign w_tab[gk] = FW'(WT);
        end else begin : g_unused
            assign w_tab[gk] = '0;
        end
    end

    t_phase                r_phase, n_phase;
    logic                  r_neg, n_neg;
    logic [INT_BITS-1:0]   r_int, n_int;
    logic [FW-1:0]         r_frac, n_frac;
    logic [FD_CNT_W-1:0]   r_fseen, n_fseen;
    logic                  r_ovf, n_ovf;

    logic                  r_out_valid;
    logic [VW-1:0]         r_value;
    t_status               r_status;
    logic                  r_line_end;

    logic                  emit;
    logic [VW-1:0]         e_value;
    t_status               e_status;
    logic                  e_line_end;

    logic                  is_digit;
    logic [3:0]            dig;
    logic                  seeking;
    logic [IE-1:0]         int_next;
    logic [FW-1:0]         w_sel;
    logic [PW-1:0]         prod;
    logic [MW-1:0]         mag;
    logic                  sat;
    logic [VW-1:0]         mag_v;

    always_comb begin
        is_digit = i_ch inside {[CH_ZERO:CH_NINE]};
        dig      = is_digit ? 4'(i_ch - CH_ZERO) : 4'd0;
        seeking  = !(r_phase == PH_INT || r_phase == PH_FRAC);
        int_next = (IE'(r_int) << 3) + (IE'(r_int) << 1) + IE'(dig);
        w_sel    = w_tab[r_fseen[TIW-1:0]];
        prod     = PW'(dig) * PW'(w_sel);
        mag      = (MW'(r_int) << FRAC_BITS) + MW'(r_frac);
        sat      = r_ovf || (mag[MW-1:MW-2] != 2'b00);
        mag_v    = sat ? MAX_MAG : VW'(mag[MW-3:0]);
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (seeking) begin
            n_phase = is_digit ? PH_INT : PH_SEEK;
        end else if (is_digit) begin
            n_phase = r_phase;
        end else if (i_ch == CH_POINT) begin
            n_phase = PH_FRAC;
        end else begin
            n_phase = PH_SEEK;
        end
    end

    // datapath and result
    always_comb begin
        n_neg      = r_neg;
        n_int      = r_int;
        n_frac     = r_frac;
        n_fseen    = r_fseen;
        n_ovf      = r_ovf;
        emit       = 1'b0;
        e_value    = '0;
        e_status   = ST_OK;
        e_line_end = 1'b0;
        if (seeking) begin
            if (is_digit) begin
                n_int   = INT_BITS'(dig);
                n_frac  = '0;
                n_fseen = '0;
                n_ovf   = 1'b0;
            end else if (i_ch == CH_NUL) begin
                emit       = 1'b1;
                e_status   = ST_NONE;
                e_line_end = 1'b1;
                n_neg      = 1'b0;
            end else if (i_ch == CH_MINUS) begin
                n_neg = !r_neg;
            end
        end else if (is_digit) begin
            case (r_phase)
                PH_INT: begin
                    if (int_next[IE-1:INT_BITS] != '0) begin
                        n_int = '1;
                        n_ovf = 1'b1;
                    end else begin
                        n_int = int_next[INT_BITS-1:0];
                    end
                end
                default: begin
                    if (r_fseen < FD_CNT_W'(MAX_FRAC_DIGITS)) begin
                        n_fseen = r_fseen + 1'b1;
                        n_frac  = r_frac + prod[FW-1:0];
                    end
                end
            endcase
        end else if (i_ch != CH_POINT) begin
            emit       = 1'b1;
            e_value    = r_neg ? (~mag_v + 1'b1) : mag_v;
            e_status   = sat ? ST_SAT : ST_OK;
            e_line_end = (i_ch == CH_NUL);
            n_int      = '0;
            n_frac     = '0;
            n_fseen    = '0;
            n_ovf      = 1'b0;
            n_neg      = (i_ch == CH_MINUS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEEK;
            r_neg       <= 1'b0;
            r_int       <= '0;
            r_frac      <= '0;
            r_fseen     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_out_valid <= i_ctl.valid && emit;
            if (i_ctl.valid) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_int   <= n_int;
                r_frac  <= n_frac;
                r_fseen <= n_fseen;
                r_ovf   <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance && i_ctl.valid && emit) begin
            r_value    <= e_value;
            r_status   <= e_status;
            r_line_end <= e_line_end;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_value    = r_value;
    assign o_status   = r_status;
    assign o_line_end = r_line_end;

    a_fseen_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fseen <= FD_CNT_W'(MAX_FRAC_DIGITS))
        else $error("fraction digit count past limit");

    a_seek_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEEK) |-> (r_int == '0 && r_frac == '0 && !r_ovf && r_fseen == '0))
        else $error("number state not cleared while seeking");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_int == '1))
        else $error("overflow without saturated integer part");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_SAT) |->
            (r_value == MAX_MAG || r_value == (~MAX_MAG + 1'b1)))
        else $error("saturated word without extreme value");

    a_none_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_NONE) |-> (r_value == '0 && r_line_end))
        else $error("no-number word malformed");

endmodule

/* hw/rtl/decimal_text_to_fixed_point.sv */
// top level: input register, handshake and parse core
// an accepted character word is held in the input register; any result word it ends is registered in the core
// throughput: one character word per cycle while the result word is not stalled, set by the single-pass parse step
// a stalled result word holds the pipe; the input register still fills when empty
// reset: synchronous active low; clears pipe valids, phase, sign and accumulators
module decimal_text_to_fixed_point #(
    parameter int INT_BITS        = dtfx_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS       = dtfx_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dtfx_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_ch,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [INT_BITS+FRAC_BITS:0]  o_value,
    output logic [1:0]                          o_status,
    output logic                                o_line_end
);
    import dtfx_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       advance;
    t_ctl       ctl;

    assign advance = !o_valid || i_ready;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch <= i_ch;
        end
    end

    assign ctl.valid   = r_in_valid;
    assign ctl.advance = advance;

    dtfx_core #(
        .INT_BITS        (INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_ch       (r_ch),
        .o_valid    (o_valid),
        .o_value    (o_value),
        .o_status   (o_status),
        .o_line_end (o_line_end)
    );

endmodule
